/* hdl/ins_pkg.sv */
// Shared types and constants for the insertion sorter.
// Used by ins_cell, insertion_sorter and tb_top; depends on nothing else.
`timescale 1ns / 1ps

package ins_pkg;

  // Width of one sort element.
  localparam int DATA_W = 32;

  // Default number of cells in the chain.
  localparam int DEPTH_DEF = 64;

  // Configuration port: address width and register addresses.
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_DESC_ADDR = 2'd0;

  // Token that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic                     vld;    // token carries a value
    logic                     shift;  // insertion point already passed: shift only
    logic                     desc;   // order that holds for this insertion
    logic signed [DATA_W-1:0] value;  // value being inserted or displaced
  } tok_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

/* hdl/ins_cell.sv */
// One cell of the systolic insertion chain: holds one sorted element.
// Depends on ins_pkg for the token type and data width.
`timescale 1ns / 1ps

module ins_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              unload,
  input  ins_pkg::tok_t                     tok_in,
  input  logic signed [ins_pkg::DATA_W-1:0] nb_value,
  input  logic                              nb_vld,
  output ins_pkg::tok_t                     tok_out,
  output logic signed [ins_pkg::DATA_W-1:0] value_out,
  output logic                              vld_out
);

  logic signed [ins_pkg::DATA_W-1:0] value_r, value_nxt;
  logic                              vld_r, vld_nxt;
  ins_pkg::tok_t                     tok_r, tok_nxt;
  logic                              goes_before;

  // The incoming value belongs in front of the held one.
  assign goes_before = tok_in.desc ? (value_r < tok_in.value) : (value_r > tok_in.value);

  // Unload shifts the chain toward the output; otherwise process the token.
  always_comb begin
    value_nxt = value_r;
    vld_nxt   = vld_r;
    tok_nxt   = '0;
    if (unload) begin
      value_nxt = nb_value;
      vld_nxt   = nb_vld;
    end else if (tok_in.vld) begin
      if (!vld_r) begin
        // Empty cell: the token comes to rest here.
        value_nxt = tok_in.value;
        vld_nxt   = 1'b1;
      end else if (tok_in.shift || goes_before) begin
        // Take the incoming value and push the held one to the right.
        value_nxt     = tok_in.value;
        tok_nxt.vld   = 1'b1;
        tok_nxt.shift = 1'b1;
        tok_nxt.desc  = tok_in.desc;
        tok_nxt.value = value_r;
      end else begin
        // Keep the held value and pass the token on.
        tok_nxt = tok_in;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  // Stored element.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign tok_out   = tok_r;
  assign value_out = value_r;
  assign vld_out   = vld_r;

endmodule

/* hdl/insertion_sorter.sv */
// Insertion sorter: one value is accepted per cycle while a set loads.
// After the beat flagged last, the chain settles in ST_DRAIN, then ST_EMIT unloads the
// n stored values back to back through the result registers; busy spans both states.
// The chain length sets the settle time. rst_n is synchronous: store empty, ascending order.
`timescale 1ns / 1ps

module insertion_sorter #(
  parameter int DEPTH = ins_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ins_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_in,
  // Result channel
  output logic                              out_valid,
  output logic signed [ins_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_last_out,
  output logic                              out_overflow,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ins_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  ins_pkg::state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                  drain_r, drain_nxt;
  logic                              drop_r, drop_nxt;
  logic                              desc_r;
  logic                              accept;
  logic                              full;
  logic                              unload;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [ins_pkg::DATA_W-1:0] out_value_r;
  logic                              out_last_r;
  logic                              out_ovf_r;
  ins_pkg::tok_t                     tok_head;

  ins_pkg::tok_t                     tok   [DEPTH+1];
  logic signed [ins_pkg::DATA_W-1:0] value [DEPTH+1];
  logic                              vld   [DEPTH+1];

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {31'd0, desc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == ins_pkg::REG_DESC_ADDR)) begin
      desc_r <= pwdata[0];
    end
  end

  // Beat acceptance; a value arriving at a full store is dropped.
  assign busy   = (state_r != ins_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign unload = (state_r == ins_pkg::ST_EMIT);

  // Entry token for the head of the chain.
  always_comb begin
    tok_head       = '0;
    tok_head.vld   = accept && !full;
    tok_head.desc  = desc_r;
    tok_head.value = in_value;
  end

  assign tok[0] = tok_head;

  // Tail of the chain: nothing shifts in from beyond the last cell.
  assign value[DEPTH] = '0;
  assign vld[DEPTH]   = 1'b0;

  // The cell chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ins_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .unload    (unload),
      .tok_in    (tok[i]),
      .nb_value  (value[i+1]),
      .nb_vld    (vld[i+1]),
      .tok_out   (tok[i+1]),
      .value_out (value[i]),
      .vld_out   (vld[i])
    );
  end

  // Sequencer: load, let the chain settle, then unload one element per cycle.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drain_nxt     = drain_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ins_pkg::ST_IDLE: begin
        if (accept) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_last_in) begin
            state_nxt = ins_pkg::ST_DRAIN;
            drain_nxt = CNT_W'(DEPTH - 1);
          end
        end
      end
      ins_pkg::ST_DRAIN: begin
        drain_nxt = drain_r - CNT_W'(1);
        if (drain_r <= CNT_W'(1)) begin
          state_nxt = ins_pkg::ST_EMIT;
        end
      end
      ins_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ins_pkg::ST_IDLE;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ins_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ins_pkg::ST_IDLE;
      cnt_r       <= '0;
      drain_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result beat registers, loaded from the head cell.
  always_ff @(posedge clk) begin
    if (unload) begin
      out_value_r <= value[0];
      out_last_r  <= (cnt_r == CNT_W'(1));
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  // The fill count never passes the chain length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds chain length");

  // No token ever falls off the end of the chain.
  a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
    !tok[DEPTH].vld)
    else $error("token left the last cell");

  // While unloading, the head cell always holds an element.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    unload |-> vld[0])
    else $error("unloading an empty head cell");

  // A result beat comes only from an unload cycle.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(unload))
    else $error("result beat without unload");

  // The final beat of a set is followed by no further beat.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result beat after last beat");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for insertion_sorter: streams sets of signed values in both orders.
// A built-in sort predictor checks every emitted beat. Depends on ins_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SORT_DEPTH  = ins_pkg::DEPTH_DEF;
  localparam int ITEM_TARGET = 430;
  localparam int SETTLE_CYC  = SORT_DEPTH + 8;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_BEAT,
    CMD_WRITE,
    CMD_HOLD
  } plan_kind_t;

  typedef struct {
    plan_kind_t         kind;
    logic signed [31:0] value;
    logic               last;
    int                 gap;
  } plan_step_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_beat_t;

  // DUT connections, all inputs known from time zero.
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [ins_pkg::DATA_W-1:0] in_value = '0;
  logic                              in_last_in = 1'b0;
  logic                              out_valid;
  logic signed [ins_pkg::DATA_W-1:0] out_sorted_value;
  logic                              out_last_out;
  logic                              out_overflow;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [ins_pkg::ADDR_W-1:0]        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  // Stimulus plan and expected sorted output.
  plan_step_t   beat_plan[$];
  sorted_beat_t sorted_expect[$];

  // Sort predictor state.
  logic signed [31:0] held_vals[SORT_DEPTH];
  int                 held_count = 0;
  logic               held_dropped = 1'b0;
  logic               sort_desc = 1'b0;

  // Driver state.
  logic       drv_on = 1'b0;
  logic       offering = 1'b0;
  logic       step_live = 1'b0;
  plan_step_t cur_step;
  int         gap_left = 0;
  int         settle_left = 0;
  int         wr_phase = 0;
  logic       burst_mode = 1'b0;

  // Monitor state.
  logic beat_taken = 1'b0;
  int   err_count = 0;
  int   stall_cycles = 0;

  insertion_sorter #(
    .DEPTH(SORT_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Insert one accepted value; on the last beat of a set, queue the whole sorted set.
  task automatic sort_insert(input logic signed [31:0] v, input logic last);
    int pos;
    if (held_count >= SORT_DEPTH) begin
      held_dropped = 1'b1;
    end else begin
      pos = held_count;
      for (int i = 0; i < held_count; i++) begin
        if (pos == held_count && (sort_desc ? (held_vals[i] < v) : (held_vals[i] > v)))
          pos = i;
      end
      for (int i = held_count; i > pos; i--)
        held_vals[i] = held_vals[i-1];
      held_vals[pos] = v;
      held_count++;
    end
    if (last) begin
      for (int i = 0; i < held_count; i++)
        sorted_expect.push_back('{held_vals[i], i == held_count - 1, held_dropped});
      held_count = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Compare one emitted beat with the oldest expected one.
  task automatic check_sorted_beat();
    sorted_beat_t want;
    if (sorted_expect.size() == 0) begin
      note_error($sformatf("unexpected beat value=%0d last=%0b ovf=%0b",
                           out_sorted_value, out_last_out, out_overflow));
    end else begin
      want = sorted_expect.pop_front();
      if (out_sorted_value !== want.value || out_last_out !== want.last ||
          out_overflow !== want.ovf)
        note_error($sformatf("exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                             want.value, want.last, want.ovf,
                             out_sorted_value, out_last_out, out_overflow));
    end
  endtask

  // Monitor: samples both channels and the register port at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      beat_taken <= start && !busy;
      if (start && !busy)
        sort_insert(in_value, in_last_in);
      // The order register reads back as last written.
      if (prdata !== {31'b0, sort_desc})
        note_error($sformatf("exp prdata=%0h, got prdata=%0h",
                             {31'b0, sort_desc}, prdata));
      if (psel && penable && pwrite && pready && paddr == ins_pkg::REG_DESC_ADDR)
        sort_desc = pwdata[0];
      if (out_valid)
        check_sorted_beat();
      if ((start && !busy) || out_valid || (psel && penable && pwrite && pready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Driver: works through the plan at the falling edge.
  always @(negedge clk) begin
    if (drv_on) begin
      if (offering && beat_taken)
        offering = 1'b0;
      if (wr_phase == 2)
        wr_phase = 0;
      else if (wr_phase == 1)
        wr_phase = 2;
      if (!step_live && !offering && wr_phase == 0 && beat_plan.size() > 0) begin
        cur_step = beat_plan.pop_front();
        step_live = 1'b1;
        gap_left = cur_step.gap;
        settle_left = SETTLE_CYC;
      end
      if (step_live) begin
        case (cur_step.kind)
          CMD_BEAT: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              offering = 1'b1;
              step_live = 1'b0;
            end
          end
          default: begin
            // Wait until every sorted beat is out and the chain has settled.
            if (sorted_expect.size() != 0 || busy) begin
              settle_left = SETTLE_CYC;
            end else if (settle_left > 0) begin
              settle_left--;
            end else begin
              step_live = 1'b0;
              if (cur_step.kind == CMD_WRITE)
                wr_phase = 1;
            end
          end
        endcase
      end
      start <= offering;
      in_value <= offering ? cur_step.value : $urandom;
      in_last_in <= offering ? cur_step.last : 1'($urandom_range(0, 1));
      psel <= (wr_phase != 0);
      penable <= (wr_phase == 2);
      pwrite <= (wr_phase != 0);
      paddr <= ins_pkg::REG_DESC_ADDR;
      pwdata <= (wr_phase != 0) ? {31'b0, cur_step.last} : 32'b0;
    end
  end

  task automatic add_beat(input logic signed [31:0] v, input logic last);
    beat_plan.push_back('{CMD_BEAT, v, last, burst_mode ? 0 : $urandom_range(0, 12)});
  endtask

  // The order bit rides in the last field of a write step.
  task automatic add_write(input logic desc);
    beat_plan.push_back('{CMD_WRITE, '0, desc, 0});
  endtask

  task automatic add_hold();
    beat_plan.push_back('{CMD_HOLD, '0, 1'b0, 0});
  endtask

  // Mix of full-range values, a narrow band full of ties, and the extremes.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  initial begin
    int  set_len;
    int  n_items;
    int  set_no;
    logic timed_out;
    n_items = 0;
    set_no = 0;
    timed_out = 1'b0;

    // Ascending from reset: extremes, zero, minus one and ties.
    add_beat(VAL_MAX, 1'b0);
    add_beat(VAL_MIN, 1'b0);
    add_beat(32'sd0, 1'b0);
    add_beat(-32'sd1, 1'b0);
    add_beat(32'sd1, 1'b0);
    add_beat(32'sd5, 1'b0);
    add_beat(32'sd5, 1'b1);
    // A set of a single element.
    add_beat(-32'sd7, 1'b1);
    // Descending order with alternating bit patterns.
    add_write(1'b1);
    add_beat(VAL_MIN, 1'b0);
    add_beat(32'sh5555_5555, 1'b0);
    add_beat(VAL_MAX, 1'b0);
    add_beat(32'shAAAA_AAAA, 1'b0);
    add_beat(32'sd7, 1'b0);
    add_beat(32'sd7, 1'b1);
    // Order flips partway through a set, so the emitted set is mixed.
    add_beat(32'sd3, 1'b0);
    add_beat(32'sd9, 1'b0);
    add_write(1'b0);
    add_beat(32'sd1, 1'b0);
    add_beat(32'sd12, 1'b0);
    add_beat(-32'sd2, 1'b1);

    // Random sets: mostly short, a few that fill or overflow the store.
    while (n_items < ITEM_TARGET) begin
      if (set_no == 0)
        set_len = SORT_DEPTH;
      else if (set_no == 1)
        set_len = SORT_DEPTH + 3;
      else if ($urandom_range(0, 7) == 0)
        set_len = $urandom_range(SORT_DEPTH - 2, SORT_DEPTH + 4);
      else
        set_len = $urandom_range(1, 12);
      burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0)
        add_write(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 5) == 0)
        add_hold();
      for (int k = 0; k < set_len; k++) begin
        if (k > 0 && $urandom_range(0, 15) == 0)
          add_write(1'($urandom_range(0, 1)));
        add_beat(pick_value(), k == set_len - 1);
      end
      n_items += set_len;
      set_no++;
    end

    // Reset, then hand the plan to the driver.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drv_on <= 1'b1;

    while (!timed_out && !(beat_plan.size() == 0 && !step_live && !offering &&
                           wr_phase == 0 && sorted_expect.size() == 0 && !busy)) begin
      @(posedge clk);
      if (stall_cycles >= STALL_LIMIT)
        timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (SORT_DEPTH + 16) @(posedge clk);
      if (err_count == 0 && sorted_expect.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule
